// ===== rtl/fsb_pkg.sv =====
`default_nettype none
package fsb_pkg;

   localparam int DISPLAY_WIDTH  = 128;
   localparam int DISPLAY_HEIGHT = 16;
   localparam int GLYPH_ROWS     = 7;
   localparam int COL_AW         = $clog2(DISPLAY_WIDTH);
   localparam int ROW_AW         = $clog2(DISPLAY_HEIGHT);
   localparam int GLYPH_COUNT    = 96;
   localparam int CURSOR_W       = 12;
   localparam int TC_W           = 13;
   localparam logic [6:0] FIRST_CODE = 7'h20;
   localparam logic [DISPLAY_HEIGHT-1:0] LOW_ROWS = DISPLAY_HEIGHT'((1 << GLYPH_ROWS) - 1);

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_DRAW    = 2'd1,
      OP_MEASURE = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_COL,
      ST_RD_A,
      ST_WR_A,
      ST_RD_B,
      ST_WR_B,
      ST_RD_PIX,
      ST_PIX,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                      clear;
      logic                      rd_en;
      logic [COL_AW-1:0]         rd_addr;
      logic                      wr_en;
      logic [COL_AW-1:0]         wr_addr;
      logic [DISPLAY_HEIGHT-1:0] wr_data;
   } fsb_mem_req_type;

   // {width, col0, col1, col2, col3, col4}; bit r of a column is glyph row r
   localparam logic [42:0] GLYPH_ROM [GLYPH_COUNT] = '{
      {3'd3, 40'h0000000000}, {3'd3, 40'h005F000000},
      {3'd5, 40'h0007000700}, {3'd5, 40'h147F147F14},
      {3'd5, 40'h242A7F2A12}, {3'd5, 40'h2313086462},
      {3'd5, 40'h3649552250}, {3'd3, 40'h0005030000},
      {3'd3, 40'h1C22410000}, {3'd3, 40'h41221C0000},
      {3'd5, 40'h082A1C2A08}, {3'd5, 40'h08083E0808},
      {3'd3, 40'h0050300000}, {3'd4, 40'h0008080000},
      {3'd4, 40'h0060600000}, {3'd5, 40'h2010080402},
      {3'd5, 40'h3E5149453E}, {3'd5, 40'h00427F4000},
      {3'd5, 40'h4261514946}, {3'd5, 40'h2141454B31},
      {3'd5, 40'h1814127F10}, {3'd5, 40'h2745454539},
      {3'd5, 40'h3C4A494930}, {3'd5, 40'h0171090503},
      {3'd5, 40'h3649494936}, {3'd5, 40'h064949291E},
      {3'd4, 40'h0036360000}, {3'd4, 40'h0056360000},
      {3'd5, 40'h0008142241}, {3'd5, 40'h1414141414},
      {3'd5, 40'h4122140800}, {3'd5, 40'h0201510906},
      {3'd5, 40'h324979413E}, {3'd5, 40'h7E1111117E},
      {3'd5, 40'h7F49494936}, {3'd5, 40'h3E41414122},
      {3'd5, 40'h7F4141221C}, {3'd5, 40'h7F49494941},
      {3'd4, 40'h7F09090100}, {3'd5, 40'h3E41415132},
      {3'd5, 40'h7F0808087F}, {3'd3, 40'h417F410000},
      {3'd5, 40'h2040413F01}, {3'd5, 40'h7F08142241},
      {3'd5, 40'h7F40404040}, {3'd5, 40'h7F0204027F},
      {3'd5, 40'h7F0408107F}, {3'd5, 40'h3E4141413E},
      {3'd5, 40'h7F09090906}, {3'd5, 40'h3E4151215E},
      {3'd5, 40'h7F09192946}, {3'd5, 40'h4649494931},
      {3'd5, 40'h01017F0101}, {3'd5, 40'h3F4040403F},
      {3'd5, 40'h1F2040201F}, {3'd5, 40'h7F2018207F},
      {3'd5, 40'h6314081463}, {3'd5, 40'h0304780403},
      {3'd5, 40'h6151494543}, {3'd4, 40'h007F414100},
      {3'd5, 40'h0204081020}, {3'd4, 40'h41417F0000},
      {3'd5, 40'h0402010204}, {3'd5, 40'h4040404040},
      {3'd3, 40'h0102040000}, {3'd4, 40'h2054547800},
      {3'd5, 40'h7F48444438}, {3'd4, 40'h3844440800},
      {3'd4, 40'h3844447F00}, {3'd4, 40'h3854541800},
      {3'd4, 40'h087E090100}, {3'd4, 40'h0854543C00},
      {3'd4, 40'h7F08047800}, {3'd3, 40'h007D000000},
      {3'd5, 40'h2040443D00}, {3'd5, 40'h007F102844},
      {3'd3, 40'h417F400000}, {3'd5, 40'h7C04180478},
      {3'd4, 40'h7C08047800}, {3'd4, 40'h3844443800},
      {3'd4, 40'h7C14140800}, {3'd5, 40'h081414187C},
      {3'd4, 40'h7C08040400}, {3'd4, 40'h4854542400},
      {3'd3, 40'h043F444020}, {3'd4, 40'h3C40403C00},
      {3'd5, 40'h1C2040201C}, {3'd5, 40'h3C4030403C},
      {3'd5, 40'h4428102844}, {3'd4, 40'h0C50503C00},
      {3'd5, 40'h4464544C44}, {3'd4, 40'h0008364100},
      {3'd3, 40'h00007F0000}, {3'd4, 40'h0041360800},
      {3'd5, 40'h08082A1C08}, {3'd5, 40'h081C2A0808}
   };

   function automatic logic [6:0] glyph_index(input logic [6:0] code);
      logic [6:0] idx;
      idx = (code >= FIRST_CODE) ? (code - FIRST_CODE) : 7'd0;
      return idx;
   endfunction

   function automatic logic [2:0] glyph_width(input logic [6:0] idx);
      logic [42:0] e;
      e = GLYPH_ROM[idx];
      return e[42:40];
   endfunction

   function automatic logic [6:0] glyph_col(input logic [6:0] idx, input logic [2:0] c);
      logic [42:0] e;
      logic [6:0]  r;
      e = GLYPH_ROM[idx];
      case (c)
         3'd0: r = e[38:32];
         3'd1: r = e[30:24];
         3'd2: r = e[22:16];
         3'd3: r = e[14:8];
         3'd4: r = e[6:0];
         default: r = 7'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/fsb_ifs.sv =====
`default_nettype none
interface fsb_req_if;
   import fsb_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        operation;
   logic [6:0]        character;
   logic              start_string;
   logic signed [10:0] start_col;
   logic signed [5:0] top_row;
   logic [2:0]        scale;
   logic signed [7:0] motion;
   logic [7:0]        pixel_x;
   logic [4:0]        pixel_y;

   modport source (output valid, operation, character, start_string, start_col, top_row,
                   scale, motion, pixel_x, pixel_y, input ready);
   modport sink (input valid, operation, character, start_string, start_col, top_row,
                 scale, motion, pixel_x, pixel_y, output ready);
endinterface

interface fsb_rsp_if;
   import fsb_pkg::*;
   logic               valid;
   logic               ready;
   logic               pixel_value;
   logic signed [11:0] next_cursor;
   logic               char_visible;

   modport source (output valid, pixel_value, next_cursor, char_visible, input ready);
   modport sink (input valid, pixel_value, next_cursor, char_visible, output ready);
endinterface
`default_nettype wire

// ===== rtl/fsb_frame_mem.sv =====
`default_nettype none
module fsb_frame_mem
   import fsb_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire fsb_mem_req_type           mem_req,
   output logic     [DISPLAY_HEIGHT-1:0]  rd_data
);

   logic [DISPLAY_HEIGHT-1:0] mem_ff [DISPLAY_WIDTH];
   logic [DISPLAY_WIDTH-1:0]  valid_ff;
   logic [DISPLAY_HEIGHT-1:0] rd_data_ff;
   logic                      rd_valid_ff;

   // column words
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff  <= mem_ff[mem_req.rd_addr];
         rd_valid_ff <= valid_ff[mem_req.rd_addr];
      end
   end

   // unwritten columns read as zero; clear drops all at once
   always_ff @(posedge clock) begin
      if (reset || mem_req.clear) begin
         valid_ff <= '0;
      end else if (mem_req.wr_en) begin
         valid_ff[mem_req.wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

// ===== rtl/fsb_row_map.sv =====
`default_nettype none
module fsb_row_map
   import fsb_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      load,
   input  wire logic signed [5:0]         top_row,
   input  wire logic        [2:0]         scale,
   input  wire logic        [6:0]         col_bits,
   output logic             [DISPLAY_HEIGHT-1:0] col_pixels,
   output logic             [DISPLAY_HEIGHT-1:0] row_mask
);

   logic [DISPLAY_HEIGHT-1:0] row_en_ff, row_en_in;
   logic [2:0]                row_idx_ff [DISPLAY_HEIGHT];
   logic [2:0]                row_idx_in [DISPLAY_HEIGHT];

   // per display row: covered by the glyph, and which glyph row lands there
   always_comb begin
      logic signed [7:0] d;
      logic        [5:0] span;
      logic        [5:0] step;
      logic        [2:0] cnt;
      span = 6'(GLYPH_ROWS) * {3'b0, scale};
      for (int tr = 0; tr < DISPLAY_HEIGHT; tr++) begin
         d   = 8'(tr) - {{2{top_row[5]}}, top_row};
         cnt = 3'd0;
         for (int j = 1; j < GLYPH_ROWS; j++) begin
            step = 6'(j) * {3'b0, scale};
            if (d >= $signed({2'b0, step})) begin
               cnt = cnt + 3'd1;
            end
         end
         row_en_in[tr]  = (d >= 8'sd0) && (d < $signed({2'b0, span}));
         row_idx_in[tr] = cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         row_en_ff  <= row_en_in;
         row_idx_ff <= row_idx_in;
      end
   end

   always_comb begin
      logic [7:0] bits;
      bits = {1'b0, col_bits};
      for (int tr = 0; tr < DISPLAY_HEIGHT; tr++) begin
         col_pixels[tr] = row_en_ff[tr] & bits[row_idx_ff[tr]];
      end
   end

   assign row_mask = row_en_ff;

endmodule
`default_nettype wire

// ===== rtl/scaled_font_text_blitter_top.sv =====
`default_nettype none
// channel   dir  handshake            word
// req_bus   in   valid/ready          operation, character, start_string, start_col,
//                                     top_row, scale, motion, pixel_x, pixel_y
// rsp_bus   out  valid/ready          pixel_value, next_cursor, char_visible
//
// A draw that misses the display or has scale 0 writes no column; a visible draw
// visits every target column (glyph width * scale of them): one off display is
// skipped, else the column memory takes a read-modify-write of it and, unless the
// moved copy falls off display, a second one of the moved column.
// One word in flight; the next word is taken as soon as the result sits in the
// output register. Reset is synchronous; it empties the frame and zeroes the cursor.
module scaled_font_text_blitter_top
   import fsb_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   fsb_req_if.sink   req_bus,
   fsb_rsp_if.source rsp_bus
);

   state_type state_ff, state_in;

   // captured word
   logic [1:0]                 op_ff;
   logic [6:0]                 idx_ff;
   logic [2:0]                 sc_ff;
   logic signed [7:0]          mo_ff;
   logic signed [5:0]          y0_ff;
   logic [7:0]                 px_ff;
   logic [4:0]                 py_ff;
   logic signed [CURSOR_W-1:0] cur_ff;     // start column of this glyph

   logic signed [CURSOR_W-1:0] cursor_ff;  // running text cursor
   logic signed [TC_W-1:0]     tc_ff;      // current target column
   logic [2:0]                 c_ff;       // glyph column
   logic [2:0]                 sx_ff;      // replica within glyph column
   logic [5:0]                 rem_ff;     // target columns left
   logic                       vis_ff;
   logic                       pix_ff;

   logic                       rsp_valid_ff;
   logic                       rsp_pix_ff;
   logic signed [CURSOR_W-1:0] rsp_cursor_ff;
   logic                       rsp_vis_ff;

   fsb_mem_req_type            mem_req;
   logic [DISPLAY_HEIGHT-1:0]  rd_data;
   logic [DISPLAY_HEIGHT-1:0]  col_pixels;
   logic [DISPLAY_HEIGHT-1:0]  row_mask;
   logic                       row_load;
   logic                       advance;
   logic                       rsp_load;
   logic                       req_take;

   logic [2:0]                 width;
   logic [5:0]                 span;
   logic signed [13:0]         sum;
   logic signed [13:0]         cursor_next;
   logic                       vis_now;
   logic signed [13:0]         tcb;
   logic                       tc_in, tcb_in;
   logic [DISPLAY_HEIGHT-1:0]  mask_a, mask_b;

   fsb_frame_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   fsb_row_map u_rows (
      .clock      (clock),
      .load       (row_load),
      .top_row    (y0_ff),
      .scale      (sc_ff),
      .col_bits   (glyph_col(idx_ff, c_ff)),
      .col_pixels (col_pixels),
      .row_mask   (row_mask)
   );

   // next cursor = cur + width*scale + scale - 1, saturated
   always_comb begin
      width = glyph_width(idx_ff);
      span  = {3'b0, width} * {3'b0, sc_ff};
      sum   = 14'(cur_ff) + $signed({8'b0, span}) + $signed({11'b0, sc_ff}) - 14'sd1;
      if (sum > 14'sd2047) begin
         cursor_next = 14'sd2047;
      end else if (sum < -14'sd2048) begin
         cursor_next = -14'sd2048;
      end else begin
         cursor_next = sum;
      end
      vis_now = (op_type'(op_ff) == OP_DRAW)
              && (14'(cur_ff) + $signed({8'b0, span}) > 14'sd0)
              && (cur_ff < $signed(CURSOR_W'(DISPLAY_WIDTH)));
   end

   // target column checked before motion; moved copy of rows 0..6 checked after
   always_comb begin
      tcb    = 14'(tc_ff) + 14'(mo_ff);
      tc_in  = (tc_ff >= 0) && (tc_ff < $signed(TC_W'(DISPLAY_WIDTH)));
      tcb_in = (tcb >= 0) && (tcb < $signed(14'(DISPLAY_WIDTH)));
      mask_a = row_mask & ~LOW_ROWS;
      mask_b = row_mask & LOW_ROWS;
   end

   assign req_take = req_bus.valid && req_bus.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               case (op_type'(req_bus.operation))
                  OP_CLEAR: state_in = ST_DONE;
                  OP_READ:  state_in = ST_RD_PIX;
                  default:  state_in = ST_SETUP;
               endcase
            end
         end
         ST_SETUP:  state_in = (vis_now && sc_ff != 3'd0) ? ST_COL : ST_DONE;
         ST_COL: begin
            if (rem_ff == 6'd0) begin
               state_in = ST_DONE;
            end else if (tc_in) begin
               state_in = ST_RD_A;
            end
         end
         ST_RD_A:   state_in = ST_WR_A;
         ST_WR_A:   state_in = tcb_in ? ST_RD_B : ST_COL;
         ST_RD_B:   state_in = ST_WR_B;
         ST_WR_B:   state_in = ST_COL;
         ST_RD_PIX: state_in = ST_PIX;
         ST_PIX:    state_in = ST_DONE;
         ST_DONE:   state_in = (!rsp_valid_ff || rsp_bus.ready) ? ST_IDLE : ST_DONE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      mem_req       = '0;
      row_load      = 1'b0;
      advance       = 1'b0;
      rsp_load      = 1'b0;
      req_bus.ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            mem_req.clear = req_bus.valid && (op_type'(req_bus.operation) == OP_CLEAR);
         end
         ST_SETUP: row_load = 1'b1;
         ST_COL:   advance  = (rem_ff != 6'd0) && !tc_in;
         ST_RD_A: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = tc_ff[COL_AW-1:0];
         end
         ST_WR_A: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = tc_ff[COL_AW-1:0];
            mem_req.wr_data = (rd_data & ~mask_a) | (col_pixels & mask_a);
            advance         = !tcb_in;
         end
         ST_RD_B: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = tcb[COL_AW-1:0];
         end
         ST_WR_B: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = tcb[COL_AW-1:0];
            mem_req.wr_data = (rd_data & ~mask_b) | (col_pixels & mask_b);
            advance         = 1'b1;
         end
         ST_RD_PIX: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = px_ff[COL_AW-1:0];
         end
         ST_DONE:  rsp_load = !rsp_valid_ff || rsp_bus.ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_SETUP) begin
            cursor_ff <= cursor_next[CURSOR_W-1:0];
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff  <= req_bus.operation;
         idx_ff <= glyph_index(req_bus.character);
         sc_ff  <= req_bus.scale;
         mo_ff  <= req_bus.motion;
         y0_ff  <= req_bus.top_row;
         px_ff  <= req_bus.pixel_x;
         py_ff  <= req_bus.pixel_y;
         cur_ff <= req_bus.start_string ? CURSOR_W'(req_bus.start_col) : cursor_ff;
         vis_ff <= 1'b0;
         pix_ff <= 1'b0;
      end
      if (state_ff == ST_SETUP) begin
         vis_ff <= vis_now;
         tc_ff  <= TC_W'(cur_ff);
         c_ff   <= 3'd0;
         sx_ff  <= 3'd0;
         rem_ff <= span;
      end
      if (advance) begin
         tc_ff  <= tc_ff + 1'b1;
         rem_ff <= rem_ff - 6'd1;
         if (sx_ff + 3'd1 == sc_ff) begin
            sx_ff <= 3'd0;
            c_ff  <= c_ff + 3'd1;
         end else begin
            sx_ff <= sx_ff + 3'd1;
         end
      end
      if (state_ff == ST_PIX) begin
         pix_ff <= ({3'b0, px_ff} < 11'(DISPLAY_WIDTH))
                && ({1'b0, py_ff} < 6'(DISPLAY_HEIGHT))
                && rd_data[py_ff[ROW_AW-1:0]];
      end
      if (rsp_load) begin
         rsp_pix_ff    <= pix_ff;
         rsp_cursor_ff <= cursor_ff;
         rsp_vis_ff    <= vis_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.pixel_value  = rsp_pix_ff;
   assign rsp_bus.next_cursor  = rsp_cursor_ff;
   assign rsp_bus.char_visible = rsp_vis_ff;

`ifndef NO_ASSERTIONS
   // every column write is the back half of a read-modify-write of that column
   a_rmw_pair: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> $past(mem_req.rd_en) && ($past(mem_req.rd_addr) == mem_req.wr_addr))
      else $error("column write without matching read");

   // cursor moves only at the end of glyph setup
   a_cursor_hold: assert property (@(posedge clock) disable iff (reset)
      !$stable(cursor_ff) |-> $past(state_ff) == ST_SETUP)
      else $error("cursor changed outside setup");

   // a new result only comes out of the done state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside done");

   // no memory reads or writes while waiting for a word
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mem_req.wr_en && !mem_req.rd_en)
      else $error("memory access while idle");
`endif

endmodule
`default_nettype wire

// ===== dv/scaled_font_text_blitter_top_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module scaled_font_text_blitter_top_tb;
   import fsb_pkg::*;

   // one request word as the sender sees it
   typedef struct {
      op_type            op;
      logic [6:0]        ch;
      logic              start;
      logic signed [10:0] xo;
      logic signed [5:0] yo;
      logic [2:0]        sc;
      logic signed [7:0] mo;
      logic [7:0]        px;
      logic [4:0]        py;
   } text_cmd_type;

   // one response word
   typedef struct {
      logic              pix;
      logic signed [11:0] cursor;
      logic              vis;
   } blit_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fsb_req_if req_bus ();
   fsb_rsp_if rsp_bus ();

   scaled_font_text_blitter_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   always #2 clock = ~clock;

   // shadow of the frame store and the text cursor
   logic [DISPLAY_HEIGHT-1:0] shadow_frame [DISPLAY_WIDTH];
   int                        shadow_cursor;

   blit_result_type pending_results[$];
   bit           failed;
   bit           quiet;        // no random idling on either side
   int           hold_cycles;  // receiver hold-off countdown

   // ---------------------------------------------------------------
   // Predictor: frame update, cursor advance and the expected word
   // ---------------------------------------------------------------
   function automatic blit_result_type predict_blit(text_cmd_type w);
      blit_result_type r;
      logic [42:0]  g;
      logic [6:0]   bits;
      int           gw, sc, cur, span, nxt, tc, tr, col;
      r.pix = 1'b0;
      r.vis = 1'b0;
      if (w.op == OP_CLEAR) begin
         foreach (shadow_frame[i]) shadow_frame[i] = '0;
      end else if (w.op == OP_READ) begin
         if (w.px < DISPLAY_WIDTH && w.py < DISPLAY_HEIGHT)
            r.pix = shadow_frame[w.px][w.py];
      end else begin
         // codes below the table start use the blank space glyph
         g    = GLYPH_ROM[(w.ch >= FIRST_CODE) ? w.ch - FIRST_CODE : 0];
         gw   = g[42:40];
         sc   = w.sc;
         cur  = w.start ? int'(w.xo) : shadow_cursor;
         span = gw * sc;
         if (w.op == OP_DRAW && span + cur > 0 && cur < DISPLAY_WIDTH) begin
            r.vis = 1'b1;
            for (int c = 0; c < gw; c++) begin
               bits = g[38 - 8*c -: 7];
               for (int sx = 0; sx < sc; sx++) begin
                  tc = cur + c*sc + sx;
                  // column bound is checked before motion is applied
                  if (tc < 0 || tc >= DISPLAY_WIDTH) continue;
                  for (int gr = 0; gr < GLYPH_ROWS; gr++) begin
                     for (int sy = 0; sy < sc; sy++) begin
                        tr = int'(w.yo) + gr*sc + sy;
                        if (tr < 0 || tr >= DISPLAY_HEIGHT) continue;
                        col = tc + ((tr < GLYPH_ROWS) ? int'(w.mo) : 0);
                        if (col >= 0 && col < DISPLAY_WIDTH)
                           shadow_frame[col][tr] = bits[gr];
                     end
                  end
               end
            end
         end
         nxt = cur + span + sc - 1;
         if (nxt > 2047) nxt = 2047;
         if (nxt < -2048) nxt = -2048;
         shadow_cursor = nxt;
      end
      r.cursor = shadow_cursor[11:0];
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Sender: called right after a rising edge, drives on the falling one
   // ---------------------------------------------------------------
   task automatic send_word(text_cmd_type w);
      @(negedge clock);
      if (!quiet && $urandom_range(99) < 12) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.operation    <= w.op;
      req_bus.character    <= w.ch;
      req_bus.start_string <= w.start;
      req_bus.start_col    <= w.xo;
      req_bus.top_row      <= w.yo;
      req_bus.scale        <= w.sc;
      req_bus.motion       <= w.mo;
      req_bus.pixel_x      <= w.px;
      req_bus.pixel_y      <= w.py;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_results.push_back(predict_blit(w));
   endtask

   function automatic text_cmd_type mk_cmd(op_type op, int ch, bit st, int xo, int yo,
                                        int sc, int mo, int px, int py);
      text_cmd_type w;
      w.op = op; w.ch = 7'(ch); w.start = st; w.xo = 11'(xo); w.yo = 6'(yo);
      w.sc = 3'(sc); w.mo = 8'(mo); w.px = 8'(px); w.py = 5'(py);
      return w;
   endfunction

   // fully random fields, any op
   function automatic text_cmd_type random_cmd();
      return mk_cmd(op_type'($urandom_range(3)), $urandom_range(127), $urandom_range(1),
                    $urandom_range(2047), $urandom_range(63), $urandom_range(7),
                    $urandom_range(255), $urandom_range(255), $urandom_range(31));
   endfunction

   // read mostly inside the display so drawn pixels get observed
   function automatic text_cmd_type read_cmd();
      text_cmd_type w;
      w = random_cmd();
      w.op = OP_READ;
      if ($urandom_range(9) != 0) begin
         w.px = 8'($urandom_range(DISPLAY_WIDTH - 1));
         w.py = 5'($urandom_range(DISPLAY_HEIGHT - 1));
      end
      return w;
   endfunction

   // stop offering, then wait for every expected word
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_directed();
      send_word(mk_cmd(OP_CLEAR, 0, 1, 0, 0, 1, 0, 0, 0));
      send_word(mk_cmd(OP_DRAW, 'h41, 1, 0, 0, 1, 0, 0, 0));       // plain 'A'
      send_word(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1));
      send_word(mk_cmd(OP_DRAW, 'h7F, 0, 0, -32, 4, 127, 0, 0));   // top clip, max motion
      send_word(mk_cmd(OP_DRAW, 'h23, 1, -8, 5, 4, -128, 0, 0));   // left clip, min motion
      send_word(mk_cmd(OP_DRAW, 'h57, 1, 120, 31, 2, 0, 0, 0));    // right/bottom clip
      send_word(mk_cmd(OP_DRAW, 'h05, 1, 10, 0, 3, 0, 0, 0));      // control code -> space
      send_word(mk_cmd(OP_DRAW, 'h4D, 1, 40, 0, 0, 0, 0, 0));      // scale zero
      send_word(mk_cmd(OP_DRAW, 'h4D, 1, 20, -3, 7, 3, 0, 0));     // scale beyond range
      send_word(mk_cmd(OP_DRAW, 'h20, 1, 1023, 0, 1, 0, 0, 0));    // far right, invisible
      send_word(mk_cmd(OP_DRAW, 'h2E, 1, -1024, 0, 4, 0, 0, 0));   // far left, invisible
      send_word(mk_cmd(OP_DRAW, 'h40, 1, -14, 2, 3, 5, 0, 0));     // partly visible
      send_word(mk_cmd(OP_MEASURE, 'h5A, 0, 0, 0, 5, 0, 0, 0));
      send_word(mk_cmd(OP_READ, 0, 1, 1023, 0, 0, 0, 255, 31));    // outside display
      send_word(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 127, 15));
      send_word(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 128, 0));
      send_word(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 3, 16));
      for (int i = 0; i < 6; i++) send_word(read_cmd());
      send_word(mk_cmd(OP_CLEAR, 'h7F, 1, -1, -1, 7, -1, 255, 31));
      send_word(read_cmd());
   endtask

   // drive the cursor into the upper rail, then walk it left from the far left
   task automatic test_cursor_saturation();
      send_word(mk_cmd(OP_MEASURE, 'h57, 1, 1023, 0, 7, 0, 0, 0));
      for (int i = 0; i < 28; i++) send_word(mk_cmd(OP_MEASURE, 'h57, 0, 0, 0, 7, 0, 0, 0));
      send_word(mk_cmd(OP_DRAW, 'h41, 0, 0, 0, 2, 0, 0, 0));
      send_word(mk_cmd(OP_MEASURE, 'h41, 1, -1024, 0, 0, 0, 0, 0));
      quiet = 1'b1;
      // scale zero walks left one column per word
      for (int i = 0; i < 40; i++) send_word(mk_cmd(OP_MEASURE, 'h41, 0, 0, 0, 0, 0, 0, 0));
      quiet = 1'b0;
      send_word(mk_cmd(OP_DRAW, 'h41, 0, 0, 0, 1, 0, 0, 0));
   endtask

   // strings: start word, random glyphs, then readback; some noise
   task automatic test_random_strings(int n_words);
      text_cmd_type w;
      int        sent, len;
      bit        big;
      sent = 0;
      while (sent < n_words) begin
         if ($urandom_range(9) == 0) begin
            send_word(random_cmd());
            sent++;
            continue;
         end
         if ($urandom_range(15) == 0) begin
            send_word(mk_cmd(OP_CLEAR, 0, 0, 0, 0, 1, 0, 0, 0));
            sent++;
         end
         len = $urandom_range(1, 8);
         big = ($urandom_range(19) == 0);
         for (int k = 0; k < len; k++) begin
            w       = random_cmd();
            w.op    = ($urandom_range(7) == 0) ? OP_MEASURE : OP_DRAW;
            w.start = (k == 0);
            w.ch    = 7'($urandom_range(3) == 0 ? $urandom_range(127)
                                                : $urandom_range(32, 127));
            w.xo    = 11'($urandom_range(4) == 0 ? $urandom_range(2047)
                                                 : $urandom_range(60) - 20);
            w.yo    = 6'($urandom_range(3) == 0 ? $urandom_range(63)
                                                : $urandom_range(12) - 4);
            w.sc    = 3'(big ? $urandom_range(7) : $urandom_range(1, 2));
            w.mo    = 8'($urandom_range(2) == 0 ? $urandom_range(255)
                                                : $urandom_range(8) - 4);
            send_word(w);
            sent++;
         end
         for (int k = $urandom_range(1, 4); k > 0; k--) begin
            send_word(read_cmd());
            sent++;
         end
      end
   endtask

   // receiver holds off while the sender keeps offering words
   task automatic test_backpressure();
      @(negedge clock);
      hold_cycles = 400;
      for (int i = 0; i < 12; i++) send_word(read_cmd());
   endtask

   // sender pauses until the response side is empty
   task automatic test_pause();
      wait_drained();
      test_random_strings(20);
   endtask

   // ---------------------------------------------------------------
   // Receiver ready: random stalls, long hold-off on request
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles   <= hold_cycles - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= quiet || ($urandom_range(99) >= 12);
      end
   end

   // ---------------------------------------------------------------
   // Response checker
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      blit_result_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $error("response word with nothing expected");
            failed = 1'b1;
         end else begin
            e = pending_results.pop_front();
            if (rsp_bus.pixel_value !== e.pix) begin
               $error("pixel_value expected %0d got %0d", e.pix, rsp_bus.pixel_value);
               failed = 1'b1;
            end
            if (rsp_bus.next_cursor !== e.cursor) begin
               $error("next_cursor expected %0d got %0d", e.cursor, rsp_bus.next_cursor);
               failed = 1'b1;
            end
            if (rsp_bus.char_visible !== e.vis) begin
               $error("char_visible expected %0d got %0d", e.vis, rsp_bus.char_visible);
               failed = 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      req_bus.valid        = 1'b0;
      req_bus.operation    = OP_CLEAR;
      req_bus.character    = '0;
      req_bus.start_string = 1'b0;
      req_bus.start_col    = '0;
      req_bus.top_row      = '0;
      req_bus.scale        = '0;
      req_bus.motion       = '0;
      req_bus.pixel_x      = '0;
      req_bus.pixel_y      = '0;
      rsp_bus.ready        = 1'b0;
      hold_cycles          = 0;
      quiet                = 1'b0;
      failed               = 1'b0;
      foreach (shadow_frame[i]) shadow_frame[i] = '0;
      shadow_cursor = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_cursor_saturation();
      test_random_strings(300);
      test_backpressure();
      quiet = 1'b1;              // stretch with no idling on either side
      test_random_strings(150);
      quiet = 1'b0;
      test_pause();
      test_random_strings(170);

      @(negedge clock);
      req_bus.valid <= 1'b0;
      wait_drained();
      repeat (300) @(posedge clock);   // longest draw plus margin
      if (!failed && pending_results.size() == 0)
         $display("[scaled_font_text_blitter_top] OK");
      else
         $display("[scaled_font_text_blitter_top] ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #8ms;
      $display("[scaled_font_text_blitter_top] ERROR");
      $finish;
   end

endmodule
`default_nettype wire
